// File: src/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/aes_pkg.sv
// AES-128 package: types, S-box tables, GF(2^8) helpers, round functions.
// No dependencies.
package aes_pkg;
   localparam int Rounds    = 10;
   localparam int RkWords   = 4 * (Rounds + 1);
   localparam int BlockBits = 128;

   typedef logic [BlockBits-1:0] block_type;
   typedef logic [31:0]          word_type;

   typedef enum logic [0:0] {
      ACT_ENCRYPT = 1'b0,
      ACT_DECRYPT = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   localparam logic [7:0] FwdSbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] InvSbox [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] Rcon [Rounds] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the block sits at bits [127-8i -: 8].
   function automatic logic [7:0] get_byte(input block_type s, input int i);
      return s[BlockBits-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s, input logic inv);
      block_type o;
      int r, c, src;
      o = '0;
      for (c = 0; c < 4; c++) begin
         for (r = 0; r < 4; r++) begin
            if (inv) begin
               src = r + 4 * ((c - r + 4) % 4);
               o[BlockBits-1-8*(r+4*c) -: 8] = InvSbox[get_byte(s, src)];
            end else begin
               src = r + 4 * ((c + r) % 4);
               o[BlockBits-1-8*(r+4*c) -: 8] = FwdSbox[get_byte(s, src)];
            end
         end
      end
      return o;
   endfunction

   function automatic word_type mix_col(input word_type w, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m1 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      word_type o;
      int r;
      for (r = 0; r < 4; r++) begin
         a[r]  = w[31-8*r -: 8];
         x2[r] = xtime(a[r]);
         x4[r] = xtime(x2[r]);
         x8[r] = xtime(x4[r]);
         m1[r] = a[r];
         m2[r] = x2[r];
         m3[r] = x2[r] ^ a[r];
         m9[r] = x8[r] ^ a[r];
         mb[r] = x8[r] ^ x2[r] ^ a[r];
         md[r] = x8[r] ^ x4[r] ^ a[r];
         me[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      for (r = 0; r < 4; r++) begin
         if (inv)
            o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
         else
            o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ m1[(r+2)%4] ^ m1[(r+3)%4];
      end
      return o;
   endfunction

   function automatic block_type mix_cols(input block_type s, input logic inv);
      block_type o;
      int c;
      o = '0;
      for (c = 0; c < 4; c++)
         o[BlockBits-1-32*c -: 32] = mix_col(s[BlockBits-1-32*c -: 32], inv);
      return o;
   endfunction

   function automatic word_type sub_word(input word_type w);
      return {FwdSbox[w[31:24]], FwdSbox[w[23:16]], FwdSbox[w[15:8]], FwdSbox[w[7:0]]};
   endfunction
endpackage

// File: src/aes_key_expand.sv
// AES-128 key schedule: one round key per cycle after a key write.
// Depends on aes_pkg.
module aes_key_expand (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [127:0]        key,
   output logic                busy,
   output aes_pkg::block_type  rkeys [aes_pkg::Rounds+1]
);
   import aes_pkg::*;

   block_type rk_ff [Rounds+1];
   logic [3:0] step_ff, step_in;
   logic       busy_ff, busy_in;
   block_type  next_rk;
   word_type   t;

   always_comb begin
      block_type p;
      p = rk_ff[step_ff];
      t = sub_word({p[23:0], p[31:24]}) ^ {Rcon[step_ff], 24'h0};
      next_rk[127:96] = p[127:96] ^ t;
      next_rk[95:64]  = p[95:64] ^ next_rk[127:96];
      next_rk[63:32]  = p[63:32] ^ next_rk[95:64];
      next_rk[31:0]   = p[31:0] ^ next_rk[63:32];
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(Rounds - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         // All-zero key; its expansion runs once start is raised after reset.
         rk_ff[0] <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (start) rk_ff[0] <= key;
         else if (busy_ff) rk_ff[step_ff + 4'd1] <= next_rk;
      end
   end

   assign busy  = busy_ff;
   assign rkeys = rk_ff;
endmodule

// File: src/aes128_block_cipher.sv
// AES-128 ECB engine, stage 0 adds the first round key of the mode, then one round per stage (11 stages).
// One block per cycle sustained while rsp is not stalled and no key is being rebuilt.
// A stall on rsp freezes the whole pipe; req_tready = (!rsp_tvalid || rsp_tready) with no key write or rebuild.
// Reset is synchronous: empties the pipe, zero key, req_tready low while the schedule is built.
// A key write holds req_tready low in the write cycle and through the re-expansion that follows.
// Depends on aes_pkg and aes_key_expand.
module aes128_block_cipher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_high[63:0], block_low[127:64]
   input  logic         req_tuser,  // action (0 encrypt, 1 decrypt)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_high[63:0], result_low[127:64]
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import aes_pkg::*;

   logic [63:0] key_hi_ff, key_lo_ff;
   logic        kstart_ff;
   logic        kbusy;
   block_type   rkeys [Rounds+1];
   block_type   blk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         kstart_ff <= 1'b1;
      end else begin
         kstart_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEY_HIGH: key_hi_ff <= csr_wdata;
               CSR_KEY_LOW:  key_lo_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   aes_key_expand u_kexp (
      .clock (clock),
      .reset (reset),
      .start (kstart_ff),
      .key   ({key_hi_ff, key_lo_ff}),
      .busy  (kbusy),
      .rkeys (rkeys)
   );

   // Stage 0 adds round key 0 (encrypt) or round key 10 (decrypt); stages 1..10 each do one round.
   block_type st_ff  [Rounds+1];
   logic      act_ff [Rounds+1];
   logic      vld_ff [Rounds+1];
   logic      adv;

   // Internal block keeps byte 0 in the top bits.
   assign blk_in     = {req_tdata[63:0], req_tdata[127:64]};
   assign adv        = !vld_ff[Rounds] || rsp_tready;
   // No transfer while the round keys are being rebuilt.
   assign req_tready = adv && !kstart_ff && !kbusy && !csr_we;
   assign rsp_tvalid = vld_ff[Rounds];
   assign rsp_tdata  = {st_ff[Rounds][63:0], st_ff[Rounds][127:64]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Rounds; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid && req_tready;
         for (int i = 1; i <= Rounds; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act_ff[0] <= req_tuser;
         st_ff[0]  <= blk_in ^ (req_tuser == ACT_DECRYPT ? rkeys[Rounds] : rkeys[0]);
         for (int i = 1; i <= Rounds; i++) begin
            act_ff[i] <= act_ff[i-1];
            if (act_ff[i-1] == ACT_DECRYPT) begin
               // Decrypt: inverse shift/sub, add key, inverse mix unless last.
               if (i == Rounds)
                  st_ff[i] <= sub_shift(st_ff[i-1], 1'b1) ^ rkeys[Rounds-i];
               else
                  st_ff[i] <= mix_cols(sub_shift(st_ff[i-1], 1'b1) ^ rkeys[Rounds-i], 1'b1);
            end else begin
               if (i == Rounds)
                  st_ff[i] <= sub_shift(st_ff[i-1], 1'b0) ^ rkeys[i];
               else
                  st_ff[i] <= mix_cols(sub_shift(st_ff[i-1], 1'b0), 1'b0) ^ rkeys[i];
            end
         end
      end
   end
endmodule

// File: src/aes_checker.sv
// Port-level checker for aes128_block_cipher, bound into the aes128_block_cipher module.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module aes_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [127:0] rsp_tdata
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPL(a_valid_known, clock, reset, 1'b1, !$isunknown(rsp_tvalid))
   `ASSERT_IMPL(a_ready_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
endmodule

bind aes128_block_cipher aes_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: tb/aes128_block_cipher_checker.sv
// Scoreboard for the AES-128 ECB engine: keeps its own key schedule and cipher model,
// predicts every block accepted on req and compares each rsp transfer in order.
// Depends on aes_pkg only for the action and CSR index constants.
`timescale 1ns / 100ps
module aes128_block_cipher_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output int           failures,
   output int           pending,
   output int           results_checked
);
   import aes_pkg::*;

   logic [7:0]   sbox_fwd [256];
   logic [7:0]   sbox_inv [256];
   logic [31:0]  sched [44];
   logic [63:0]  key_hi, key_lo;
   logic [127:0] expected_blocks [$];

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   // S-box built from the field inverse and the affine map.
   initial begin
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sbox_fwd[x] = s;
         sbox_inv[s] = x[7:0];
      end
   end

   task automatic rebuild_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      sched[0] = key_hi[63:32];
      sched[1] = key_hi[31:0];
      sched[2] = key_lo[63:32];
      sched[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         t = sched[i-1];
         if (i % 4 == 0) begin
            t = {sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]], sbox_fwd[t[31:24]]}
                ^ {rc, 24'h0};
            rc = gf_mul(rc, 8'h02);
         end
         sched[i] = sched[i-4] ^ t;
      end
   endtask

   function automatic logic [127:0] round_key(input int n);
      return {sched[4*n], sched[4*n+1], sched[4*n+2], sched[4*n+3]};
   endfunction

   // byte k of a block lives at [127-8k -: 8]
   function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic dec);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = r + 4 * (dec ? ((c - r + 4) & 3) : ((c + r) & 3));
            o[127-8*(r+4*c) -: 8] = dec ? sbox_inv[s[127-8*src -: 8]]
                                        : sbox_fwd[s[127-8*src -: 8]];
         end
      return o;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic dec);
      logic [7:0]   coef [4];
      logic [7:0]   v;
      logic [127:0] o;
      if (dec) begin
         coef[0] = 8'd14;
         coef[1] = 8'd11;
         coef[2] = 8'd13;
         coef[3] = 8'd9;
      end else begin
         coef[0] = 8'd2;
         coef[1] = 8'd3;
         coef[2] = 8'd1;
         coef[3] = 8'd1;
      end
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++)
               v ^= gf_mul(s[127-8*(k+4*c) -: 8], coef[(k - r + 4) & 3]);
            o[127-8*(r+4*c) -: 8] = v;
         end
      return o;
   endfunction

   function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
      logic [127:0] s;
      if (dec == ACT_ENCRYPT) begin
         s = blk ^ round_key(0);
         for (int n = 1; n <= 10; n++) begin
            s = shift_sub(s, 1'b0);
            if (n != 10) s = mix(s, 1'b0);
            s ^= round_key(n);
         end
      end else begin
         s = blk ^ round_key(10);
         for (int n = 9; n >= 0; n--) begin
            s = shift_sub(s, 1'b1) ^ round_key(n);
            if (n != 0) s = mix(s, 1'b1);
         end
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: %s mismatch: expected %h got %h", $realtime, what, want, got);
      failures++;
   endtask

   initial begin
      failures = 0;
      results_checked = 0;
      pending = 0;
   end

   // tdata carries the high half in the low bits
   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         rebuild_schedule();
         expected_blocks.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_KEY_HIGH) key_hi = csr_wdata;
            else key_lo = csr_wdata;
            rebuild_schedule();
         end
         if (req_tvalid && req_tready)
            expected_blocks.push_back(cipher_block(req_tuser,
                                                   {req_tdata[63:0], req_tdata[127:64]}));
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_blocks.size() == 0) begin
               $display("%0t: result transfer with nothing expected: %h", $realtime,
                        rsp_tdata);
               failures++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata[63:0] !== want[127:64])
                  report_mismatch("result_high", want[127:64], rsp_tdata[63:0]);
               if (rsp_tdata[127:64] !== want[63:0])
                  report_mismatch("result_low", want[63:0], rsp_tdata[127:64]);
            end
         end
      end
      pending = expected_blocks.size();
   end
endmodule

// File: tb/aes128_block_cipher_test.sv
// Top of the AES-128 engine testbench: clock, reset, key writes, block stimulus,
// result back-pressure, watchdog and verdict. Depends on aes_pkg, the engine
// and aes128_block_cipher_checker.
`timescale 1ns / 100ps
module aes128_block_cipher_test;
   import aes_pkg::*;

   localparam int IdleLimit = 3000;  // cycles with no transfer or key write before giving up
   localparam int SettleCycles = 24; // wait after a key write, with margin over the key schedule
   localparam int DrainCycles = 30;  // drain wait, with margin over the pipe

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // block_high[63:0], block_low[127:64]
   logic         req_tuser;   // action
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // result_high[63:0], result_low[127:64]
   logic         csr_we;
   logic [0:0]   csr_index;
   logic [63:0]  csr_wdata;

   int failures, pending, results_checked;
   int blocks_sent, key_writes, idle_cycles;
   bit sender_burst, receiver_burst, long_hold_request;

   aes128_block_cipher uut (.*);

   aes128_block_cipher_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // All inputs known from time zero.
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_ENCRYPT;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_wdata = '0;
   end

   // Watchdog: any transfer, key write or reset counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Watchdog expired with %0d results outstanding", pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stall per result, quiet stretches, one long hold-off.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_request) begin
            stall = 400;
            long_hold_request = 1'b0;
         end else begin
            stall = receiver_burst ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // One block transfer on req; gap is drawn per item unless in a burst.
   task automatic send_block(input action_type act, input logic [63:0] hi,
                             input logic [63:0] lo);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {lo, hi};
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
   endtask

   // Key writes only with the pipe empty; then let the schedule settle.
   task automatic write_key(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DrainCycles) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      key_writes++;
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0001;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic action_type rand_action();
      return $urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT;
   endfunction

   initial begin
      int seg_len;
      blocks_sent = 0;
      key_writes = 0;
      long_hold_request = 1'b0;
      sender_burst = 1'b0;
      receiver_burst = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      repeat (SettleCycles) @(negedge clock);

      // Directed: zero key straight out of reset.
      send_block(ACT_ENCRYPT, '0, '0);
      send_block(ACT_DECRYPT, '0, '0);
      send_block(ACT_ENCRYPT, '1, '1);
      send_block(ACT_DECRYPT, '1, '1);

      // Standard known-answer pair with key 00 01 .. 0f.
      write_key(CSR_KEY_HIGH, 64'h0001_0203_0405_0607);
      // mixed key: only the high half is new so far
      send_block(ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      send_block(ACT_DECRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      write_key(CSR_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
      send_block(ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      send_block(ACT_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
      send_block(ACT_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      send_block(ACT_DECRYPT, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);

      // All-ones key.
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW, '1);
      send_block(ACT_ENCRYPT, '0, '1);
      send_block(ACT_DECRYPT, '1, '0);
      send_block(ACT_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);

      // Random segments, each with a fresh key (sometimes only one half changes).
      for (int seg = 0; seg < 12; seg++) begin
         case ($urandom_range(0, 3))
            0: write_key(CSR_KEY_HIGH, rand64());
            1: write_key(CSR_KEY_LOW, rand64());
            default: begin
               write_key(CSR_KEY_HIGH, rand64());
               write_key(CSR_KEY_LOW, rand64());
            end
         endcase
         if (seg == 4) long_hold_request = 1'b1;  // block fills up and stalls req
         seg_len = $urandom_range(80, 110);
         for (int n = 0; n < seg_len; n++) begin
            if (n % 25 == 0) begin
               sender_burst = ($urandom_range(0, 3) == 0) || seg == 4;
               receiver_burst = ($urandom_range(0, 3) == 0) && seg != 4;
            end
            send_block(rand_action(), rand64(), rand64());
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DrainCycles) @(negedge clock);

      $display("Covered %0d blocks (encrypt and decrypt) under %0d key writes,",
               blocks_sent, key_writes);
      $display("%0d results checked, including mixed-key and back-pressure phases.",
               results_checked);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/aes_pkg.sv
src/aes_key_expand.sv
src/aes128_block_cipher.sv
src/aes_checker.sv
tb/aes128_block_cipher_checker.sv
tb/aes128_block_cipher_test.sv
